// File: rtl/repeating_broadcast_scheduler_macros.svh
// Assertion macros for the repeating broadcast scheduler.
`ifndef REPEATING_BROADCAST_SCHEDULER_MACROS_SVH
`define REPEATING_BROADCAST_SCHEDULER_MACROS_SVH
`ifndef ASSERT_OFF
`define RBS_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");
`define RBS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define RBS_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define RBS_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: rtl/rbs_pkg.sv
package rbs_pkg;

    typedef enum logic [1:0] {
        REQ_DELETE = 2'd0,
        REQ_MODIFY = 2'd1,
        REQ_ADD    = 2'd2,
        REQ_TICK   = 2'd3
    } t_req;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_DISABLED = 2'd3;

    typedef struct packed {
        logic [31:0] ident;
        logic [31:0] message;
        logic [31:0] due;
        logic [31:0] period;
        logic [31:0] limit;
        logic [31:0] sent;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic start;
        logic add;
        logic rd_issue;
        logic proc;
        logic finish;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_req req;
        logic enabled;
        logic scan_done;
        logic fire_needed;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/repeating_broadcast_scheduler.sv
// Repeating broadcast scheduler: a table of up to TABLE_DEPTH broadcasts kept in
// insertion order in a single-port memory with registered read. One input word is
// taken at a time. A request made while disabled goes straight to its reply, and an
// add writes the new entry at the fill mark. Delete, modify and tick walk the table
// entry by entry (read, then process and write back compacted); each fired
// broadcast may hold the walk while the output is stalled.
// Every input ends with one word with last set; a tick emits one word per broadcast
// fired before it. The next input may be taken while the final word still waits.
`include "repeating_broadcast_scheduler_macros.svh"
module repeating_broadcast_scheduler #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_entry_id,
    input  logic [31:0] i_message_id,
    input  logic [31:0] i_start_time,
    input  logic [31:0] i_repeat_interval,
    input  logic [31:0] i_repeat_limit,
    input  logic [31:0] i_now_time,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [31:0] o_out_entry_id,
    output logic [31:0] o_out_message_id,
    output logic [1:0]  o_status,
    output logic        o_last
);

    rbs_pkg::t_cmd w_cmd;
    rbs_pkg::t_sts w_sts;

    rbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rbs_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_req_type        (i_req_type),
        .i_entry_id        (i_entry_id),
        .i_message_id      (i_message_id),
        .i_start_time      (i_start_time),
        .i_repeat_interval (i_repeat_interval),
        .i_repeat_limit    (i_repeat_limit),
        .i_now_time        (i_now_time),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_result_kind     (o_result_kind),
        .o_out_entry_id    (o_out_entry_id),
        .o_out_message_id  (o_out_message_id),
        .o_status          (o_status),
        .o_last            (o_last),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts)
    );

    `RBS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `RBS_ASSERT_IMPLY(a_emit_needs_room, i_clk, i_rst_n, w_cmd.emit, w_sts.out_free)
    `RBS_ASSERT_IMPLY(a_proc_in_range, i_clk, i_rst_n, w_cmd.proc, !w_sts.scan_done)

endmodule

// File: rtl/rbs_ctrl.sv
module rbs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  rbs_pkg::t_sts i_sts,
    output rbs_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ADD   = 5'b00010,
        S_READ  = 5'b00100,
        S_PROC  = 5'b01000,
        S_REPLY = 5'b10000
    } t_state;

    t_state r_state, n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = S_READ;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state = S_REPLY;
            end
            S_READ: begin
                if (!i_sts.enabled) begin
                    n_state = S_REPLY;
                end else if (i_sts.req == rbs_pkg::REQ_ADD) begin
                    n_state = S_ADD;
                end else if (i_sts.scan_done) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_REPLY;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state = S_PROC;
                end
            end
            S_PROC: begin
                // hold while a fired word cannot enter the output register
                if (!i_sts.fire_needed || i_sts.out_free) begin
                    o_cmd.proc = 1'b1;
                    n_state = S_READ;
                end
            end
            S_REPLY: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

// File: rtl/rbs_dpath.sv
module rbs_dpath #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_data,
    input  logic [1:0]    i_req_type,
    input  logic [31:0]   i_entry_id,
    input  logic [31:0]   i_message_id,
    input  logic [31:0]   i_start_time,
    input  logic [31:0]   i_repeat_interval,
    input  logic [31:0]   i_repeat_limit,
    input  logic [31:0]   i_now_time,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output logic          o_result_kind,
    output logic [31:0]   o_out_entry_id,
    output logic [31:0]   o_out_message_id,
    output logic [1:0]    o_status,
    output logic          o_last,
    input  rbs_pkg::t_cmd i_cmd,
    output rbs_pkg::t_sts o_sts
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    rbs_pkg::t_entry mem [TABLE_DEPTH];
    rbs_pkg::t_entry r_rdata;

    logic          r_enabled;
    logic [CW-1:0] r_count, r_rd, r_wr;
    logic [31:0]   r_auto;
    logic          r_found;
    rbs_pkg::t_req r_req;
    logic [31:0]   r_id, r_msg, r_start, r_period, r_limit, r_now;
    logic [31:0]   r_rep_id;
    logic [1:0]    r_rep_st;
    logic          r_out_valid;

    logic            w_tick, w_match, w_drop, w_fire, w_full, w_we;
    logic [AW-1:0]   w_waddr;
    logic [31:0]     w_nid, w_auto_inc;
    rbs_pkg::t_entry w_wdata, w_upd;

    assign w_tick  = (r_req == rbs_pkg::REQ_TICK);
    assign w_match = (r_rdata.ident == r_id) && !r_found;
    assign w_drop  = w_tick ? (r_rdata.sent >= r_rdata.limit)
                            : ((r_req == rbs_pkg::REQ_DELETE) && w_match);
    assign w_fire  = w_tick && !w_drop && (r_rdata.due < r_now);
    assign w_full  = (r_count == FULL_COUNT);
    assign w_nid   = (r_id == 32'd0) ? r_auto : r_id;
    assign w_auto_inc = r_auto + 32'd1;

    always_comb begin
        w_upd = r_rdata;
        if (w_fire) begin
            w_upd.sent = r_rdata.sent + 32'd1;
            w_upd.due  = r_now + r_rdata.period;
        end
        if ((r_req == rbs_pkg::REQ_MODIFY) && w_match) begin
            w_upd.message = r_msg;
            w_upd.due     = r_start;
            w_upd.period  = r_period;
            w_upd.limit   = r_limit;
        end
    end

    // add appends at the fill mark; a scan writes kept entries back compacted
    always_comb begin
        if (i_cmd.add) begin
            w_we    = !w_full;
            w_waddr = r_count[AW-1:0];
            w_wdata = '{ident: w_nid, message: r_msg, due: r_start,
                        period: r_period, limit: r_limit, sent: 32'd0};
        end else begin
            w_we    = i_cmd.proc && !w_drop;
            w_waddr = r_wr[AW-1:0];
            w_wdata = w_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        if (i_cmd.rd_issue) r_rdata <= mem[r_rd[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req    <= rbs_pkg::t_req'(i_req_type);
            r_id     <= i_entry_id;
            r_msg    <= i_message_id;
            r_start  <= i_start_time;
            r_period <= i_repeat_interval;
            r_limit  <= i_repeat_limit;
            r_now    <= i_now_time;
            r_rd     <= '0;
            r_wr     <= '0;
            r_found  <= 1'b0;
            r_rep_id <= 32'd0;
            r_rep_st <= rbs_pkg::ST_DISABLED;
        end
        if (i_cmd.add) begin
            r_rep_id <= w_full ? 32'd0 : w_nid;
            r_rep_st <= w_full ? rbs_pkg::ST_FULL : rbs_pkg::ST_OK;
        end
        if (i_cmd.proc) begin
            r_rd <= r_rd + CW'(1);
            if (!w_drop) r_wr <= r_wr + CW'(1);
            if (w_match && !w_tick) r_found <= 1'b1;
        end
        if (i_cmd.finish) begin
            r_rep_id <= (!w_tick && r_found) ? r_id : 32'd0;
            r_rep_st <= (w_tick || r_found) ? rbs_pkg::ST_OK : rbs_pkg::ST_NOTFOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b1;
            r_count   <= '0;
            r_auto    <= 32'd1;
        end else begin
            if (i_cfg_we) r_enabled <= i_cfg_data;
            if (i_cmd.add && !w_full) begin
                r_count <= r_count + CW'(1);
                if (r_id == 32'd0) r_auto <= (w_auto_inc == 32'd0) ? 32'd1 : w_auto_inc;
            end
            if (i_cmd.finish) r_count <= r_wr;
        end
    end

    // output register: load a fired word or the closing word, drop on take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.proc && w_fire) || i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.proc && w_fire) begin
            o_result_kind    <= 1'b1;
            o_out_entry_id   <= r_rdata.ident;
            o_out_message_id <= r_rdata.message;
            o_status         <= rbs_pkg::ST_OK;
            o_last           <= 1'b0;
        end else if (i_cmd.emit) begin
            o_result_kind    <= 1'b0;
            o_out_entry_id   <= r_rep_id;
            o_out_message_id <= 32'd0;
            o_status         <= r_rep_st;
            o_last           <= 1'b1;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_sts.req         = r_req;
    assign o_sts.enabled     = r_enabled;
    assign o_sts.scan_done   = (r_rd == r_count);
    assign o_sts.fire_needed = w_fire;
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

endmodule

// File: test/repeating_broadcast_scheduler_checker.sv
module repeating_broadcast_scheduler_checker #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_entry_id,
    input  logic [31:0] i_message_id,
    input  logic [31:0] i_start_time,
    input  logic [31:0] i_repeat_interval,
    input  logic [31:0] i_repeat_limit,
    input  logic [31:0] i_now_time,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_result_kind,
    input  logic [31:0] i_out_entry_id,
    input  logic [31:0] i_out_message_id,
    input  logic [1:0]  i_status,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_fired_count,
    output int          o_word_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        kind;
        logic [31:0] ident;
        logic [31:0] message;
        logic [1:0]  status;
        logic        last;
    } t_word;

    t_word  expected_words[$];
    rbs_pkg::t_entry sched_table[TABLE_DEPTH];
    int     table_count;
    logic [31:0] auto_id;
    logic   enabled;

    assign o_pending = expected_words.size();

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    function automatic t_word mk(logic k, logic [31:0] id, logic [31:0] m,
                                 logic [1:0] s, logic l);
        t_word w;
        w.kind = k; w.ident = id; w.message = m; w.status = s; w.last = l;
        return w;
    endfunction

    task automatic queue_word(t_word w);
        expected_words.insert(expected_words.size(), w);
    endtask

    function automatic int lookup(logic [31:0] id);
        for (int i = 0; i < table_count; i++)
            if (sched_table[i].ident == id) return i;
        return -1;
    endfunction

    task automatic drop_slot(int p);
        for (int i = p; i + 1 < table_count; i++) sched_table[i] = sched_table[i + 1];
        table_count--;
    endtask

    task automatic predict_request();
        int p;
        int i;
        logic [31:0] nid;
        if (!enabled) begin
            queue_word(mk(0, 0, 0, rbs_pkg::ST_DISABLED, 1));
            return;
        end
        case (rbs_pkg::t_req'(i_req_type))
            rbs_pkg::REQ_DELETE: begin
                p = lookup(i_entry_id);
                if (p < 0) queue_word(mk(0, 0, 0, rbs_pkg::ST_NOTFOUND, 1));
                else begin
                    drop_slot(p);
                    queue_word(mk(0, i_entry_id, 0, rbs_pkg::ST_OK, 1));
                end
            end
            rbs_pkg::REQ_MODIFY: begin
                p = lookup(i_entry_id);
                if (p < 0) queue_word(mk(0, 0, 0, rbs_pkg::ST_NOTFOUND, 1));
                else begin
                    sched_table[p].message = i_message_id;
                    sched_table[p].due     = i_start_time;
                    sched_table[p].period  = i_repeat_interval;
                    sched_table[p].limit   = i_repeat_limit;
                    queue_word(mk(0, i_entry_id, 0, rbs_pkg::ST_OK, 1));
                end
            end
            rbs_pkg::REQ_ADD: begin
                if (table_count >= TABLE_DEPTH) begin
                    queue_word(mk(0, 0, 0, rbs_pkg::ST_FULL, 1));
                end else begin
                    if (i_entry_id == 0) begin
                        nid = auto_id;
                        auto_id = auto_id + 1;
                        if (auto_id == 0) auto_id = 1;
                    end else nid = i_entry_id;
                    sched_table[table_count] = '{nid, i_message_id, i_start_time,
                        i_repeat_interval, i_repeat_limit, 32'd0};
                    table_count++;
                    queue_word(mk(0, nid, 0, rbs_pkg::ST_OK, 1));
                end
            end
            default: begin
                i = 0;
                while (i < table_count) begin
                    if (sched_table[i].sent >= sched_table[i].limit) begin
                        drop_slot(i);
                        continue;
                    end
                    if (sched_table[i].due < i_now_time) begin
                        queue_word(mk(1, sched_table[i].ident,
                            sched_table[i].message, rbs_pkg::ST_OK, 0));
                        sched_table[i].sent = sched_table[i].sent + 1;
                        sched_table[i].due  = i_now_time + sched_table[i].period;
                    end
                    i++;
                end
                queue_word(mk(0, 0, 0, rbs_pkg::ST_OK, 1));
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            expected_words.delete();
            table_count = 0;
            auto_id = 1;
            enabled = 1;
            o_fail_count = 0;
            o_fired_count = 0;
            o_word_count = 0;
        end else begin
            if (i_cfg_we) enabled = i_cfg_data;
            if (i_in_valid && !i_in_stall) predict_request();
            if (i_out_valid && !i_out_stall) begin
                o_word_count++;
                if (i_result_kind) o_fired_count++;
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", i_out_entry_id, 0);
                end else begin
                    w = expected_words.pop_front();
                    if (i_result_kind !== w.kind) report_mismatch("kind", i_result_kind, w.kind);
                    if (i_out_entry_id !== w.ident)
                        report_mismatch("entry id", i_out_entry_id, w.ident);
                    if (i_out_message_id !== w.message)
                        report_mismatch("message id", i_out_message_id, w.message);
                    if (i_status !== w.status) report_mismatch("status", i_status, w.status);
                    if (i_last !== w.last) report_mismatch("last", i_last, w.last);
                end
            end
        end
    end
endmodule

// File: test/repeating_broadcast_scheduler_tb.sv
module repeating_broadcast_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic        cfg_data = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  req_type = 0;
    logic [31:0] entry_id = 0, message_id = 0, start_time = 0;
    logic [31:0] repeat_interval = 0, repeat_limit = 0, now_time = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic        result_kind, last;
    logic [31:0] out_entry_id, out_message_id;
    logic [1:0]  status;
    int          fail_count, pending, fired_count, word_count;
    int          idle_cycles = 0;
    bit          hold_off = 0;
    bit          timed_out = 0;
    logic [31:0] clock_now = 100;
    logic [31:0] used_ids[$];

    always #4 clk = ~clk;

    repeating_broadcast_scheduler dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_req_type(req_type),
        .i_entry_id(entry_id), .i_message_id(message_id), .i_start_time(start_time),
        .i_repeat_interval(repeat_interval), .i_repeat_limit(repeat_limit),
        .i_now_time(now_time), .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_result_kind(result_kind), .o_out_entry_id(out_entry_id),
        .o_out_message_id(out_message_id), .o_status(status), .o_last(last)
    );

    repeating_broadcast_scheduler_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_req_type(req_type),
        .i_entry_id(entry_id), .i_message_id(message_id), .i_start_time(start_time),
        .i_repeat_interval(repeat_interval), .i_repeat_limit(repeat_limit),
        .i_now_time(now_time), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_result_kind(result_kind), .i_out_entry_id(out_entry_id),
        .i_out_message_id(out_message_id), .i_status(status), .i_last(last),
        .o_fail_count(fail_count), .o_pending(pending), .o_fired_count(fired_count),
        .o_word_count(word_count)
    );

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    endfunction

    // receiver stall: random, or held high during a hold-off
    always @(posedge clk) begin
        if (hold_off) out_stall <= 1;
        else if ($urandom_range(0, 3) == 0) out_stall <= ($urandom_range(0, 1) == 1);
        else out_stall <= 0;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("watchdog expired");
            $display("repeating_broadcast_scheduler verification failed");
            $finish;
        end
    end

    task automatic send_word(logic [1:0] rq, logic [31:0] id, logic [31:0] msg,
                             logic [31:0] st, logic [31:0] per, logic [31:0] lim,
                             logic [31:0] nw, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        // leave valid low between words
        repeat (g + 1) @(posedge clk);
        req_type <= rq; entry_id <= id; message_id <= msg; start_time <= st;
        repeat_interval <= per; repeat_limit <= lim; now_time <= nw;
        in_valid <= 1;
        do @(posedge clk); while (in_stall);
        in_valid <= 0;
    endtask

    task automatic wait_drain();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_enable(logic v);
        wait_drain();
        repeat (40) @(posedge clk);
        cfg_we <= 1; cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [31:0] pick_id();
        if (used_ids.size() > 0 && $urandom_range(0, 4) != 0)
            return used_ids[$urandom_range(0, used_ids.size() - 1)];
        return $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20);
    endfunction

    task automatic random_word();
        int r;
        logic [31:0] id, lim;
        r = $urandom_range(0, 9);
        id = pick_id();
        lim = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 4);
        if (r < 4) begin
            if ($urandom_range(0, 2) == 0) id = 0;
            used_ids.insert(used_ids.size(), id);
            if (used_ids.size() > 24) void'(used_ids.pop_front());
            send_word(rbs_pkg::REQ_ADD, id, $urandom, clock_now - $urandom_range(0, 50),
                      $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 30),
                      lim, $urandom, 1);
        end else if (r < 7) begin
            clock_now = ($urandom_range(0, 15) == 0) ? $urandom : clock_now + $urandom_range(0, 40);
            send_word(rbs_pkg::REQ_TICK, $urandom, $urandom, $urandom, $urandom, $urandom,
                      clock_now, 1);
        end else if (r < 8) begin
            send_word(rbs_pkg::REQ_MODIFY, id, $urandom, clock_now + $urandom_range(0, 20) - 10,
                      $urandom_range(0, 30), lim, $urandom, 1);
        end else begin
            send_word(rbs_pkg::REQ_DELETE, id, $urandom, $urandom, $urandom, $urandom,
                      $urandom, 1);
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: extremes, auto id, duplicates, full table, misses
        send_word(rbs_pkg::REQ_ADD, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        send_word(rbs_pkg::REQ_ADD, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_word(rbs_pkg::REQ_ADD, 32'hFFFF_FFFF, 32'h1234, 5, 10, 2, 0, 0);
        send_word(rbs_pkg::REQ_ADD, 32'hFFFF_FFFF, 32'h5678, 5, 10, 1, 0, 0);
        send_word(rbs_pkg::REQ_TICK, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
        send_word(rbs_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0);
        send_word(rbs_pkg::REQ_MODIFY, 32'hFFFF_FFFF, 32'hAAAA_5555, 0, 3, 3, 0, 0);
        send_word(rbs_pkg::REQ_MODIFY, 32'h0BAD_0BAD, 1, 1, 1, 1, 0, 0);
        send_word(rbs_pkg::REQ_DELETE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
        send_word(rbs_pkg::REQ_DELETE, 32'h0BAD_0BAD, 0, 0, 0, 0, 0, 0);
        for (int k = 0; k < 15; k++)
            send_word(rbs_pkg::REQ_ADD, k[1:0] == 0 ? 32'd0 : 32'd500 + k, k, 0, 1, 3, 0, 0);
        send_word(rbs_pkg::REQ_ADD, 0, 0, 0, 0, 0, 0, 0);
        send_word(rbs_pkg::REQ_TICK, 0, 0, 0, 0, 0, 50, 0);
        write_enable(0);
        send_word(rbs_pkg::REQ_ADD, 0, 1, 1, 1, 1, 1, 0);
        send_word(rbs_pkg::REQ_TICK, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
        write_enable(1);
        // drop the spent entries of the full table through ticks
        for (int k = 0; k < 5; k++)
            send_word(rbs_pkg::REQ_TICK, 0, 0, 0, 0, 0, 100 + 60 * k, 0);
        for (int n = 0; n < 70; n++) begin
            if (n == 30) begin
                fork
                    begin hold_off = 1; repeat (300) @(posedge clk); hold_off = 0; end
                    for (int k = 0; k < 8; k++) random_word();
                join
            end
            if (n == 45) wait_drain();
            if (n == 55) write_enable(0);
            if (n == 60) write_enable(1);
            random_word();
        end
        wait_drain();
        repeat (100) @(posedge clk);
        $display("covered adds, modifies, deletes and ticks with %0d words out, %0d broadcasts",
                 word_count, fired_count);
        $display("enable toggled, full table, auto ids and receiver hold-off exercised");
        if (fail_count == 0) $display("repeating_broadcast_scheduler verification clean");
        else $display("repeating_broadcast_scheduler verification failed");
        $finish;
    end
endmodule

// File: repeating_broadcast_scheduler.f
+incdir+rtl
rtl/rbs_pkg.sv
rtl/rbs_ctrl.sv
rtl/rbs_dpath.sv
rtl/repeating_broadcast_scheduler.sv
test/repeating_broadcast_scheduler_checker.sv
test/repeating_broadcast_scheduler_tb.sv
